// File: hdl/tld_pkg.sv
// Shared types and constants for the tty line discipline buffer.
// No dependencies; imported by tld_ctrl, the top level and the testbench.
`timescale 1ns / 1ps

package tld_pkg;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_UPPER_C   = 8'h43;
  localparam logic [7:0] INT_CHAR_RST = 8'd131;

  typedef enum logic [1:0] {
    KIND_ECHO    = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_INTR    = 2'd2,
    KIND_NOTHING = 2'd3
  } kind_e;

  typedef enum logic {
    REQ_PUT  = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    CFG_CANONICAL = 2'd0,
    CFG_ECHO      = 2'd1,
    CFG_ECHO_NL   = 2'd2,
    CFG_INT_CHAR  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_READ
  } state_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [6:0] read_count;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       canonical_mode;
    logic       echo_enable;
    logic       echo_newline;
    logic [7:0] interrupt_char;
  } cfg_t;

endpackage

// File: hdl/tld_store.sv
// Character ring storage: one write port, one read port, registered read data.
// Depends on nothing; contents are undefined until written.
`timescale 1ns / 1ps

module tld_store #(
  parameter int Depth = 4096,
  parameter int Aw    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tld_ctrl.sv
// Line discipline sequencer: pointers, counts, echo and read streaming.
// Depends on tld_pkg; drives the tld_store ports of the top level.
`timescale 1ns / 1ps

module tld_ctrl #(
  parameter int BufferDepth = 4096,
  parameter int MaxRead     = 64,
  parameter int Aw          = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tld_pkg::cfg_t    cfg_i,
  input  logic             start_i,
  input  tld_pkg::item_t   item_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output tld_pkg::result_t result_o,
  output logic             mem_we_o,
  output logic [Aw-1:0]    mem_waddr_o,
  output logic [7:0]       mem_wdata_o,
  output logic             mem_re_o,
  output logic [Aw-1:0]    mem_raddr_o,
  input  logic [7:0]       mem_rdata_i
);
  import tld_pkg::*;

  localparam int Cw = $clog2(BufferDepth + 1);
  localparam int Ww = (Cw > 7) ? Cw : 7;
  localparam logic [Aw-1:0] LastPtr = Aw'(BufferDepth - 1);
  localparam logic [Cw:0]   FullFill = (Cw + 1)'(BufferDepth);
  localparam logic [6:0]    MaxRd = 7'(MaxRead);

  state_e        state_q, state_d;
  logic [Aw-1:0] rptr_q, rptr_d;
  logic [Aw-1:0] wptr_q, wptr_d;
  logic [Cw-1:0] pend_q, pend_d;
  logic [Cw-1:0] comm_q, comm_d;
  logic [6:0]    issue_q, issue_d;
  logic          rd_vld_q, rd_vld_d;
  logic          rd_last_q, rd_last_d;
  logic          echo_q, echo_d;
  logic [7:0]    echo_byte_q, echo_byte_d;
  logic          caret_q, caret_d;
  logic          cee_q, cee_d;
  logic          intr_q, intr_d;
  logic          none_q, none_d;

  logic          accept;
  logic [Cw:0]   fill;
  logic [6:0]    capped;
  logic [Ww-1:0] want;
  logic [Cw-1:0] pend_st;
  logic [7:0]    c;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE) || rd_vld_q;
  assign fill   = {1'b0, comm_q} + {1'b0, pend_q};
  assign capped = (item_i.read_count > MaxRd) ? MaxRd : item_i.read_count;
  assign want   = (Ww'(capped) > Ww'(comm_q)) ? Ww'(comm_q) : Ww'(capped);
  assign c      = item_i.char_code;

  always_comb begin
    state_d     = state_q;
    rptr_d      = rptr_q;
    wptr_d      = wptr_q;
    pend_d      = pend_q;
    comm_d      = comm_q;
    issue_d     = issue_q;
    rd_vld_d    = 1'b0;
    rd_last_d   = 1'b0;
    echo_d      = echo_q;
    echo_byte_d = echo_byte_q;
    caret_d     = caret_q;
    cee_d       = cee_q;
    intr_d      = intr_q;
    none_d      = none_q;
    pend_st     = pend_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wptr_q;
    mem_wdata_o = c;
    mem_re_o    = 1'b0;
    mem_raddr_o = rptr_q;
    res_valid_o = 1'b0;
    result_o    = '{kind: KIND_DATA, data_byte: mem_rdata_i, last: rd_last_q};

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.req_type == REQ_READ) begin
            if (want == '0) begin
              none_d  = 1'b1;
              state_d = ST_EMIT;
            end else begin
              issue_d = 7'(want);
              comm_d  = comm_q - Cw'(want);
              state_d = ST_READ;
            end
          end else if (c == CH_BACKSPACE && cfg_i.canonical_mode) begin
            if (pend_q != '0) begin
              wptr_d = (wptr_q == '0) ? LastPtr : wptr_q - Aw'(1);
              pend_d = pend_q - Cw'(1);
              if (cfg_i.echo_enable) begin
                echo_d      = 1'b1;
                echo_byte_d = CH_BACKSPACE;
                state_d     = ST_EMIT;
              end
            end
          end else begin
            if (fill < FullFill) begin
              mem_we_o = 1'b1;
              wptr_d   = (wptr_q == LastPtr) ? '0 : wptr_q + Aw'(1);
              pend_st  = pend_q + Cw'(1);
            end
            pend_d = pend_st;
            if (!c[7] && cfg_i.echo_enable) begin
              echo_d      = 1'b1;
              echo_byte_d = c;
            end else if (c == CH_NEWLINE && cfg_i.echo_newline) begin
              echo_d      = 1'b1;
              echo_byte_d = CH_NEWLINE;
            end
            if (!cfg_i.canonical_mode || c == CH_NEWLINE) begin
              comm_d = comm_q + pend_st;
              pend_d = '0;
            end
            if (c == cfg_i.interrupt_char) begin
              caret_d = cfg_i.echo_enable;
              cee_d   = cfg_i.echo_enable;
              intr_d  = 1'b1;
              if (cfg_i.canonical_mode) begin
                wptr_d = rptr_q;
                comm_d = '0;
                pend_d = '0;
              end
            end
            if (echo_d || intr_d) begin
              state_d = ST_EMIT;
            end
          end
        end
        if (rd_vld_q) begin
          res_valid_o = 1'b1;
        end
      end
      ST_EMIT: begin
        res_valid_o = 1'b1;
        if (echo_q) begin
          result_o = '{kind: KIND_ECHO, data_byte: echo_byte_q,
                       last: !(caret_q || cee_q || intr_q)};
          echo_d   = 1'b0;
        end else if (caret_q) begin
          result_o = '{kind: KIND_ECHO, data_byte: CH_CARET, last: !(cee_q || intr_q)};
          caret_d  = 1'b0;
        end else if (cee_q) begin
          result_o = '{kind: KIND_ECHO, data_byte: CH_UPPER_C, last: !intr_q};
          cee_d    = 1'b0;
        end else if (intr_q) begin
          result_o = '{kind: KIND_INTR, data_byte: 8'h00, last: 1'b1};
          intr_d   = 1'b0;
        end else begin
          result_o = '{kind: KIND_NOTHING, data_byte: 8'h00, last: 1'b1};
          none_d   = 1'b0;
        end
        if (result_o.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        res_valid_o = rd_vld_q;
        mem_re_o    = 1'b1;
        rptr_d      = (rptr_q == LastPtr) ? '0 : rptr_q + Aw'(1);
        issue_d     = issue_q - 7'd1;
        rd_vld_d    = 1'b1;
        rd_last_d   = (issue_q == 7'd1);
        if (issue_q == 7'd1) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rptr_q    <= '0;
      wptr_q    <= '0;
      pend_q    <= '0;
      comm_q    <= '0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      echo_q    <= 1'b0;
      caret_q   <= 1'b0;
      cee_q     <= 1'b0;
      intr_q    <= 1'b0;
      none_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rptr_q    <= rptr_d;
      wptr_q    <= wptr_d;
      pend_q    <= pend_d;
      comm_q    <= comm_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
      echo_q    <= echo_d;
      caret_q   <= caret_d;
      cee_q     <= cee_d;
      intr_q    <= intr_d;
      none_q    <= none_d;
    end
  end

  always_ff @(posedge clk_i) begin
    echo_byte_q <= echo_byte_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill <= FullFill)
    else $error("stored characters exceed buffer depth");

  a_read_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> issue_q != 7'd0)
    else $error("read state entered with nothing to issue");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == ST_EMIT && rd_vld_q))
    else $error("echo and read data collide on the result port");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && result_o.last |=> !res_valid_o)
    else $error("result follows the last result of a transaction");

  a_busy_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (echo_q || caret_q || cee_q || intr_q || none_q) |-> busy_o)
    else $error("pending result while idle");

endmodule

// File: hdl/tty_line_discipline_buffer_core.sv
// Top level of the tty line discipline buffer: configuration registers,
// sequencer and character storage. Depends on tld_pkg, tld_ctrl, tld_store.
`timescale 1ns / 1ps

// Transaction timing: a put transaction is accepted while busy_o is low and
// then shows its echo, caret, C and interrupt results on consecutive cycles
// (zero to four results). A read transaction of N bytes (N from 1 to MAX_READ)
// streams one byte per cycle from the registered storage read port; an empty
// read gives its single result the cycle after acceptance. busy_o stays high
// until the last result has been shown. Results appear on result_o for exactly
// one cycle with res_valid_o high and cannot be held off by the receiver.
// Storage needs no clearing after reset.
module tty_line_discipline_buffer_core #(
  parameter int BUFFER_DEPTH = 4096,
  parameter int MAX_READ     = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             start_i,
  input  tld_pkg::item_t   item_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output tld_pkg::result_t result_o
);
  import tld_pkg::*;

  localparam int Aw = $clog2(BUFFER_DEPTH);

  cfg_t          cfg_q, cfg_d;
  logic          mem_we;
  logic [Aw-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [Aw-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CANONICAL: cfg_d.canonical_mode = cfg_data_i[0];
        CFG_ECHO:      cfg_d.echo_enable    = cfg_data_i[0];
        CFG_ECHO_NL:   cfg_d.echo_newline   = cfg_data_i[0];
        CFG_INT_CHAR:  cfg_d.interrupt_char = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{canonical_mode: 1'b1, echo_enable: 1'b1, echo_newline: 1'b1,
                 interrupt_char: INT_CHAR_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tld_ctrl #(
    .BufferDepth(BUFFER_DEPTH),
    .MaxRead    (MAX_READ),
    .Aw         (Aw)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .result_o   (result_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  tld_store #(
    .Depth(BUFFER_DEPTH),
    .Aw   (Aw)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

// File: tb/tty_line_discipline_buffer_core_test.sv
// Self-checking testbench for tty_line_discipline_buffer_core: directed and random
// put/read transactions checked against a behavioral line discipline predictor.
// Depends on tld_pkg and the tty_line_discipline_buffer_core RTL.
`timescale 1ns / 1ps

module tty_line_discipline_buffer_core_test;
  import tld_pkg::*;

  localparam int DEPTH    = 4096;
  localparam int MAX_READ = 64;

  logic    clk_i;
  logic    rst_ni;
  logic    cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;
  logic    start_i;
  item_t   item_i;
  logic    busy_o;
  logic    res_valid_o;
  result_t result_o;

  tty_line_discipline_buffer_core #(
    .BUFFER_DEPTH(DEPTH),
    .MAX_READ    (MAX_READ)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .result_o   (result_o)
  );

  // Predictor state
  logic [7:0]  line_store [DEPTH];
  logic [11:0] rd_pos;
  logic [11:0] wr_pos;
  int          pend_cnt;
  int          ready_cnt;
  logic        canon_on;
  logic        echo_on;
  logic        echo_nl_on;
  logic [7:0]  intr_code;

  result_t tty_out_q[$];
  int      mismatches;
  bit      pace_on;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  function automatic void add_result(kind_e k, logic [7:0] b);
    result_t r;
    r.kind      = k;
    r.data_byte = b;
    r.last      = 1'b0;
    tty_out_q.push_back(r);
  endfunction

  function automatic void discipline_step(item_t it);
    int first;
    int want;
    logic [7:0] c;
    first = tty_out_q.size();
    c = it.char_code;
    if (it.req_type == REQ_READ) begin
      want = it.read_count;
      if (want > MAX_READ) want = MAX_READ;
      if (want > ready_cnt) want = ready_cnt;
      if (want == 0) begin
        add_result(KIND_NOTHING, 8'h00);
      end else begin
        for (int i = 0; i < want; i++) begin
          add_result(KIND_DATA, line_store[rd_pos]);
          rd_pos = rd_pos + 12'd1;
        end
        ready_cnt -= want;
      end
    end else if (c == CH_BACKSPACE && canon_on) begin
      if (pend_cnt != 0) begin
        wr_pos = wr_pos - 12'd1;
        pend_cnt--;
        if (echo_on) add_result(KIND_ECHO, CH_BACKSPACE);
      end
    end else begin
      if (ready_cnt + pend_cnt < DEPTH) begin
        line_store[wr_pos] = c;
        wr_pos = wr_pos + 12'd1;
        pend_cnt++;
      end
      if (!c[7] && echo_on) add_result(KIND_ECHO, c);
      else if (c == CH_NEWLINE && echo_nl_on) add_result(KIND_ECHO, CH_NEWLINE);
      if (!canon_on || c == CH_NEWLINE) begin
        ready_cnt += pend_cnt;
        pend_cnt = 0;
      end
      if (c == intr_code) begin
        if (echo_on) begin
          add_result(KIND_ECHO, CH_CARET);
          add_result(KIND_ECHO, CH_UPPER_C);
        end
        if (canon_on) begin
          wr_pos    = rd_pos;
          ready_cnt = 0;
          pend_cnt  = 0;
        end
        add_result(KIND_INTR, 8'h00);
      end
    end
    if (tty_out_q.size() > first) tty_out_q[tty_out_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (tty_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d byte=%02h last=%0b",
                   result_o.kind, result_o.data_byte, result_o.last);
      end else begin
        want = tty_out_q.pop_front();
        if (result_o.kind !== want.kind || result_o.data_byte !== want.data_byte ||
            result_o.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected kind=%0d byte=%02h last=%0b, got kind=%0d byte=%02h last=%0b",
                     want.kind, want.data_byte, want.last,
                     result_o.kind, result_o.data_byte, result_o.last);
        end
      end
    end
  end

  task automatic send_item(item_t it);
    while (pace_on && $urandom_range(99) < 19) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    discipline_step(it);
  endtask

  task automatic put_char(logic [7:0] c);
    item_t it;
    it.req_type   = REQ_PUT;
    it.char_code  = c;
    it.read_count = 7'($urandom);
    send_item(it);
  endtask

  task automatic read_req(logic [6:0] n);
    item_t it;
    it.req_type   = REQ_READ;
    it.char_code  = 8'($urandom);
    it.read_count = n;
    send_item(it);
  endtask

  // Hold the sender until every expected result has arrived, then let the block settle.
  task automatic wait_quiet(int extra);
    int guard;
    guard = 0;
    start_i <= 1'b0;
    while (tty_out_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_discipline(logic canon, logic echo, logic echo_nl, logic [7:0] ic);
    wait_quiet(8);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CANONICAL;
    cfg_data_i <= {7'd0, canon};
    @(posedge clk_i);
    canon_on   = canon;
    cfg_idx_i  <= CFG_ECHO;
    cfg_data_i <= {7'd0, echo};
    @(posedge clk_i);
    echo_on    = echo;
    cfg_idx_i  <= CFG_ECHO_NL;
    cfg_data_i <= {7'd0, echo_nl};
    @(posedge clk_i);
    echo_nl_on = echo_nl;
    cfg_idx_i  <= CFG_INT_CHAR;
    cfg_data_i <= ic;
    @(posedge clk_i);
    intr_code  = ic;
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Commit a line, edit the next one, then drain everything in bounded reads.
  task automatic test_line_commit();
    pace_on = 1'b0;
    set_discipline(1'b1, 1'b1, 1'b1, INT_CHAR_RST);
    for (int i = 0; i < 20; i++) put_char(8'($urandom_range(32, 126)));
    put_char(CH_NEWLINE);
    put_char("z");
    put_char("q");
    put_char(CH_BACKSPACE);
    put_char(CH_NEWLINE);
    put_char(CH_NEWLINE);
    read_req(7'd16);
    read_req(7'd16);
    read_req(7'd1);
  endtask

  task automatic test_line_editing();
    set_discipline(1'b1, 1'b1, 1'b1, INT_CHAR_RST);
    put_char(CH_BACKSPACE);
    put_char("h");
    put_char(8'h00);
    put_char(8'h7F);
    put_char(8'h80);
    put_char(8'hFF);
    put_char(CH_BACKSPACE);
    put_char(CH_BACKSPACE);
    put_char(CH_NEWLINE);
    read_req(7'd0);
    read_req(7'd127);
    read_req(7'd1);
    put_char("a");
    put_char(CH_NEWLINE);
    put_char("b");
    put_char(INT_CHAR_RST);
    read_req(7'd5);
  endtask

  task automatic test_raw_and_echo();
    set_discipline(1'b0, 1'b0, 1'b1, INT_CHAR_RST);
    put_char("a");
    put_char(CH_NEWLINE);
    put_char(8'h8A);
    put_char(CH_BACKSPACE);
    read_req(7'd64);
    set_discipline(1'b0, 1'b1, 1'b0, "a");
    put_char(8'h85);
    put_char(CH_NEWLINE);
    put_char(CH_BACKSPACE);
    put_char("a");
    read_req(7'd65);
    set_discipline(1'b1, 1'b0, 1'b0, INT_CHAR_RST);
    put_char("c");
    put_char(CH_BACKSPACE);
    put_char(CH_NEWLINE);
    read_req(7'd3);
  endtask

  task automatic test_interrupt_codes();
    set_discipline(1'b1, 1'b1, 1'b1, CH_NEWLINE);
    put_char("x");
    put_char(CH_NEWLINE);
    read_req(7'd2);
    set_discipline(1'b1, 1'b1, 1'b1, CH_BACKSPACE);
    put_char("y");
    put_char(CH_BACKSPACE);
    set_discipline(1'b0, 1'b1, 1'b0, CH_BACKSPACE);
    put_char(CH_BACKSPACE);
    read_req(7'd4);
    set_discipline(1'b1, 1'b0, 1'b1, 8'h00);
    put_char("k");
    put_char(8'h00);
    set_discipline(1'b0, 1'b1, 1'b1, 8'hFF);
    put_char(8'hFF);
    read_req(7'd8);
  endtask

  function automatic item_t random_item();
    item_t it;
    int sel;
    sel = $urandom_range(99);
    it.req_type   = REQ_PUT;
    it.char_code  = 8'($urandom_range(32, 126));
    it.read_count = 7'($urandom);
    if (sel < 22) begin
      it.req_type   = REQ_READ;
      it.char_code  = 8'($urandom);
      it.read_count = (sel < 17) ? 7'($urandom_range(1, 16)) : 7'($urandom_range(0, 127));
    end else if (sel < 34) begin
      it.char_code = CH_NEWLINE;
    end else if (sel < 42) begin
      it.char_code = CH_BACKSPACE;
    end else if (sel < 45) begin
      it.char_code = intr_code;
    end else if (sel < 60) begin
      it.char_code = 8'($urandom);
    end
    return it;
  endfunction

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_discipline(1'b1, 1'b1, 1'b1, INT_CHAR_RST);
        1: set_discipline(1'b0, 1'b0, 1'b1, 8'($urandom_range(0, 255)));
        2: set_discipline(1'b1, 1'b1, 1'b0, 8'hFF);
        default: set_discipline(1'b1, 1'b0, 1'b1, 8'($urandom_range(0, 255)));
      endcase
      pace_on = (phase != 0);
      for (int n = 0; n < 36; n++) begin
        send_item(random_item());
        if (phase == 2 && n == 18) wait_quiet(8);
      end
    end
    pace_on = 1'b0;
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_CANONICAL;
    cfg_data_i = 8'h00;
    start_i    = 1'b0;
    item_i     = '0;
    mismatches = 0;
    pace_on    = 1'b0;
    rd_pos     = '0;
    wr_pos     = '0;
    pend_cnt   = 0;
    ready_cnt  = 0;
    canon_on   = 1'b1;
    echo_on    = 1'b1;
    echo_nl_on = 1'b1;
    intr_code  = INT_CHAR_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_line_commit();
    test_line_editing();
    test_raw_and_echo();
    test_interrupt_codes();
    test_random_traffic();

    wait_quiet(80);
    if (mismatches == 0 && tty_out_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
